### rtl/lch_pkg.sv
// Shared types, constants and the log table for the log-chroma histogram.
package lch_pkg;

  localparam int BIN_BITS   = 8;
  localparam int COUNT_BITS = 20;
  localparam int ADDR_W     = 2 * BIN_BITS;
  localparam int DEPTH      = 1 << ADDR_W;

  // 64*ln(c) in Q16 needs 25 bits for c up to 255
  localparam int LOG_W  = 25;
  // gray sum 4899R + 9617G + 1868B
  localparam int GRAY_W = 23;
  localparam int THR_W  = 12;
  localparam int ORG_W  = 11;
  localparam int FRAC_W = 16;
  // log difference minus shifted origin
  localparam int D_W    = 28;

  localparam int unsigned GRAY_R_COEF = 4899;
  localparam int unsigned GRAY_G_COEF = 9617;
  localparam int unsigned GRAY_B_COEF = 1868;

  localparam logic [THR_W-1:0] BRIGHT_RESET = THR_W'(3672);
  localparam logic [THR_W-1:0] DARK_RESET   = THR_W'(408);
  localparam logic [ORG_W-1:0] ORIGIN_RESET = ORG_W'(11'h7A5);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [BIN_BITS-1:0]   bin_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LOG_W-1:0]      log_tab_t [256];

  typedef enum logic [1:0] {
    FN_ACCUM = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CFG_BRIGHT = 2'd0,
    CFG_DARK   = 2'd1,
    CFG_ORIGIN = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_COUNTED = 3'd0,
    ST_ZERO    = 3'd1,
    ST_WINDOW  = 3'd2,
    ST_READ    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] read_u;
    logic [7:0] read_v;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  bin_u;
    logic [7:0]  bin_v;
    logic [19:0] bin_count;
  } out_t;

  // 64*ln(c) in Q16, rounded to nearest; entry 0 is unused
  function automatic log_tab_t log_table_init();
    log_tab_t tab;
    real      x;
    tab[0] = '0;
    for (int c = 1; c < 256; c++) begin
      x = 64.0 * 65536.0 * $ln(real'(c)) + 0.5;
      tab[c] = LOG_W'($rtoi(x));
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TABLE = log_table_init();

endpackage

### rtl/lch_ram.sv
// Generic simple dual-port RAM with registered read.
module lch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/log_chroma_histogram.sv
// Top level: log-chroma histogram with bin counts held in one RAM.
//
//  channel | signals                              | carries
//  --------+--------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data          | func, pixel, read index
//  out     | out_valid, out_ready, out_data       | status, bins, count
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | bright, dark, origin regs
//
// One item at a time. Accumulate goes from transfer to result through table
// lookup, log difference, round/clamp, RAM read and read-modify-write. Skipped
// pixels end after the lookup or the log difference. Read: RAM read, then
// result. Clear: one RAM row per cycle, then result. After reset the same
// clearing pass runs with in_ready low; cfg writes are always taken. A result
// waiting in the output register blocks only the next item's final step.
module log_chroma_histogram (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lch_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lch_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [11:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOG,
    S_DIFF,
    S_BIN,
    S_READ,
    S_FINISH
  } state_t;

  localparam int Q_W = lch_pkg::D_W - lch_pkg::FRAC_W;

  state_t                             state;
  lch_pkg::in_t                       item;
  logic [lch_pkg::THR_W-1:0]          bright;
  logic [lch_pkg::THR_W-1:0]          dark;
  logic [lch_pkg::ORG_W-1:0]          origin;
  logic [lch_pkg::LOG_W-1:0]          log_r, log_g, log_b;
  logic [lch_pkg::GRAY_W-1:0]         gray;
  logic signed [lch_pkg::D_W-1:0]     diff_u, diff_v;
  lch_pkg::bin_t                      bin_u, bin_v;
  lch_pkg::status_t                   status;
  logic [lch_pkg::ADDR_W-1:0]         clr_addr;
  logic                               clr_report;

  logic [lch_pkg::GRAY_W-1:0]         gray_next;
  logic signed [lch_pkg::D_W-1:0]     lg_s, lr_s, lb_s, org_s;
  logic signed [lch_pkg::D_W-1:0]     diff_u_next, diff_v_next;
  logic                               in_window;
  logic                               finish_go;
  lch_pkg::count_t                    count_next;
  lch_pkg::count_t                    result_count;

  logic                               ram_wr_en;
  logic [lch_pkg::ADDR_W-1:0]         ram_wr_addr;
  lch_pkg::count_t                    ram_wr_data;
  logic                               ram_rd_en;
  logic [lch_pkg::ADDR_W-1:0]         ram_rd_addr;
  lch_pkg::count_t                    ram_rd_data;

  // round half away from zero, then clamp to 0..255
  function automatic lch_pkg::bin_t to_bin(logic signed [lch_pkg::D_W-1:0] d);
    logic [Q_W-1:0] q;
    q = d[lch_pkg::D_W-1:lch_pkg::FRAC_W] + Q_W'(d[lch_pkg::FRAC_W-1]);
    if (d[lch_pkg::D_W-1]) begin
      return '0;
    end else if (q > Q_W'((1 << lch_pkg::BIN_BITS) - 1)) begin
      return '1;
    end else begin
      return q[lch_pkg::BIN_BITS-1:0];
    end
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    gray_next = lch_pkg::GRAY_W'(lch_pkg::GRAY_R_COEF * 32'(item.red)
                                + lch_pkg::GRAY_G_COEF * 32'(item.green)
                                + lch_pkg::GRAY_B_COEF * 32'(item.blue));

    lg_s  = {{(lch_pkg::D_W - lch_pkg::LOG_W){1'b0}}, log_g};
    lr_s  = {{(lch_pkg::D_W - lch_pkg::LOG_W){1'b0}}, log_r};
    lb_s  = {{(lch_pkg::D_W - lch_pkg::LOG_W){1'b0}}, log_b};
    org_s = {{(lch_pkg::D_W - lch_pkg::ORG_W - lch_pkg::FRAC_W){origin[lch_pkg::ORG_W-1]}},
             origin, {lch_pkg::FRAC_W{1'b0}}};
    diff_u_next = lg_s - lr_s - org_s;
    diff_v_next = lg_s - lb_s - org_s;

    in_window = (gray > {1'b0, dark, 10'b0}) && (gray <= {1'b0, bright, 10'b0});

    count_next = (ram_rd_data == lch_pkg::COUNT_MAX) ? ram_rd_data
                                                     : ram_rd_data + 1'b1;
    unique case (status)
      lch_pkg::ST_COUNTED: result_count = count_next;
      lch_pkg::ST_READ:    result_count = ram_rd_data;
      default:             result_count = '0;
    endcase

    finish_go = (state == S_FINISH) && (!out_valid || out_ready);

    // one item in flight: the write-back always lands before the next read
    ram_rd_en   = (state == S_READ);
    ram_rd_addr = {bin_u, bin_v};
    ram_wr_en   = (state == S_CLEAR) || (finish_go && status == lch_pkg::ST_COUNTED);
    ram_wr_addr = (state == S_CLEAR) ? clr_addr : {bin_u, bin_v};
    ram_wr_data = (state == S_CLEAR) ? '0 : count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
      bright     <= lch_pkg::BRIGHT_RESET;
      dark       <= lch_pkg::DARK_RESET;
      origin     <= lch_pkg::ORIGIN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lch_pkg::CFG_BRIGHT: bright <= cfg_data;
          lch_pkg::CFG_DARK:   dark   <= cfg_data;
          lch_pkg::CFG_ORIGIN: origin <= cfg_data[lch_pkg::ORG_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && !finish_go) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            if (clr_report) begin
              status <= lch_pkg::ST_CLEARED;
              bin_u  <= '0;
              bin_v  <= '0;
              state  <= S_FINISH;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            unique case (in_data.func)
              lch_pkg::FN_ACCUM: state <= S_LOG;
              lch_pkg::FN_READ: begin
                bin_u  <= lch_pkg::bin_t'(in_data.read_u);
                bin_v  <= lch_pkg::bin_t'(in_data.read_v);
                status <= lch_pkg::ST_READ;
                state  <= S_READ;
              end
              lch_pkg::FN_CLEAR: begin
                clr_addr   <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOG: begin
          log_r <= lch_pkg::LOG_TABLE[item.red];
          log_g <= lch_pkg::LOG_TABLE[item.green];
          log_b <= lch_pkg::LOG_TABLE[item.blue];
          gray  <= gray_next;
          if (item.red == '0 || item.green == '0 || item.blue == '0) begin
            status <= lch_pkg::ST_ZERO;
            bin_u  <= '0;
            bin_v  <= '0;
            state  <= S_FINISH;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_u <= diff_u_next;
          diff_v <= diff_v_next;
          if (in_window) begin
            state <= S_BIN;
          end else begin
            status <= lch_pkg::ST_WINDOW;
            bin_u  <= '0;
            bin_v  <= '0;
            state  <= S_FINISH;
          end
        end
        S_BIN: begin
          bin_u  <= to_bin(diff_u);
          bin_v  <= to_bin(diff_v);
          status <= lch_pkg::ST_COUNTED;
          state  <= S_READ;
        end
        S_READ: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (finish_go) begin
            out_valid          <= 1'b1;
            out_data.status    <= status;
            out_data.bin_u     <= 8'(bin_u);
            out_data.bin_v     <= 8'(bin_v);
            out_data.bin_count <= 20'(result_count);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lch_ram #(
    .WIDTH(lch_pkg::COUNT_BITS),
    .DEPTH(lch_pkg::DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

endmodule
